@@ src/swd_pkg.sv @@
// Shared types and constants for the serial-wire-debug host transfer engine.
package swd_pkg;

  localparam int DATA_W = 32;
  localparam int CFG_W  = 8;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  localparam logic [15:0]      SWITCH_PATTERN       = 16'hE79E;
  localparam logic [2:0]       ACK_OK               = 3'b001;
  localparam logic [2:0]       ACK_WAIT             = 3'b010;
  localparam logic [CFG_W-1:0] RESET_CLOCKS_DEFAULT = 8'd50;
  localparam logic [CFG_W-1:0] LOW_IDLE_DEFAULT     = 8'd12;

  localparam logic [0:0] CFG_RESET_CLOCKS = 1'b0;
  localparam logic [0:0] CFG_LOW_IDLE     = 1'b1;

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_XFER   = 2'd1,
    FUNC_SWITCH = 2'd2
  } swd_func_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_RESET1  = 4'd1,
    PH_PATTERN = 4'd2,
    PH_RESET2  = 4'd3,
    PH_LOWIDLE = 4'd4,
    PH_REQ     = 4'd5,
    PH_TURN1   = 4'd6,
    PH_ACK     = 4'd7,
    PH_WAITCLK = 4'd8,
    PH_RDATA   = 4'd9,
    PH_RTAIL   = 4'd10,
    PH_TURN2   = 4'd11,
    PH_WDATA   = 4'd12,
    PH_WPAR    = 4'd13
  } swd_phase_t;

  // classified item handed from front to back
  typedef struct packed {
    swd_func_t         kind;
    logic [7:0]        req_byte;
    logic [1:0]        port_dir;   // bit 1 AP, bit 0 read
    logic [DATA_W-1:0] wdata;
    logic              wpar;
    logic              sdi;
  } swd_cmd_t;

  typedef struct packed {
    logic              lvl;
    logic              drive;
    logic              clk_pulse;
    logic              busy;
    logic              done;
    logic [2:0]        ack;
    logic [DATA_W-1:0] rword;
  } swd_res_t;

endpackage

@@ src/swd_host_transfer_engine.sv @@
// Top level of the serial-wire-debug host transfer engine.
// Each item pushed is one SWCLK period: func starts a switch sequence or a
// DP/AP transfer when the engine is idle, and swdio_in is the level sampled in
// that period. Every item yields exactly one result item, in order, giving the
// line level, drive enable, clock pulse, busy/done flags, ack bits and last
// read word. Items are classified on entry, wait in a short command queue,
// and are stepped by the line engine at one item per clock while the result
// queue has room, a rate set by the bit step of the line engine. Items are
// registered in the command queue and results in the result queue before they
// can be popped. Register writes take effect at the next clock edge, whatever
// is queued, so write them only while no item is queued or in progress.
module swd_host_transfer_engine #(
  parameter int CMD_DEPTH = swd_pkg::CMD_DEPTH,
  parameter int RES_DEPTH = swd_pkg::RES_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [0:0]                 cfg_index,
  input  logic [swd_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       push,
  output logic                       full,
  input  logic [1:0]                 func,
  input  logic                       ap_not_dp,
  input  logic                       read_not_write,
  input  logic [1:0]                 reg_addr,
  input  logic [swd_pkg::DATA_W-1:0] write_data,
  input  logic                       swdio_in,
  output logic                       empty,
  input  logic                       pop,
  output logic                       swdio_out,
  output logic                       swdio_drive,
  output logic                       clock_pulse,
  output logic                       busy_res,
  output logic                       done_res,
  output logic [2:0]                 ack_code,
  output logic [swd_pkg::DATA_W-1:0] read_word
);

  swd_pkg::swd_cmd_t in_cmd;
  swd_pkg::swd_cmd_t q_cmd;
  swd_pkg::swd_res_t step_res;
  swd_pkg::swd_res_t out_res;
  logic              cmd_empty;
  logic              res_full;
  logic              step;

  swd_front u_front (
    .func           (func),
    .ap_not_dp      (ap_not_dp),
    .read_not_write (read_not_write),
    .reg_addr       (reg_addr),
    .write_data     (write_data),
    .swdio_in       (swdio_in),
    .cmd            (in_cmd)
  );

  swd_fifo #(
    .WIDTH ($bits(swd_pkg::swd_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (in_cmd),
    .full      (full),
    .pop       (step),
    .pop_data  (q_cmd),
    .empty     (cmd_empty)
  );

  assign step = !cmd_empty && !res_full;

  swd_line_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .cmd       (q_cmd),
    .res       (step_res)
  );

  swd_fifo #(
    .WIDTH ($bits(swd_pkg::swd_res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk       (clk),
    .rst       (rst),
    .push      (step),
    .push_data (step_res),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (out_res),
    .empty     (empty)
  );

  assign swdio_out   = out_res.lvl;
  assign swdio_drive = out_res.drive;
  assign clock_pulse = out_res.clk_pulse;
  assign busy_res    = out_res.busy;
  assign done_res    = out_res.done;
  assign ack_code    = out_res.ack;
  assign read_word   = out_res.rword;

endmodule

@@ src/swd_fifo.sv @@
// Small register queue used between the front, the line engine and the result port.
module swd_fifo #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/swd_front.sv @@
// Front end: classifies an incoming item and builds the request byte and write parity.
module swd_front (
  input  logic [1:0]                 func,
  input  logic                       ap_not_dp,
  input  logic                       read_not_write,
  input  logic [1:0]                 reg_addr,
  input  logic [swd_pkg::DATA_W-1:0] write_data,
  input  logic                       swdio_in,
  output swd_pkg::swd_cmd_t          cmd
);

  logic req_par;

  assign req_par = ap_not_dp ^ read_not_write ^ reg_addr[1] ^ reg_addr[0];

  always_comb begin
    case (func)
      swd_pkg::FUNC_XFER:   cmd.kind = swd_pkg::FUNC_XFER;
      swd_pkg::FUNC_SWITCH: cmd.kind = swd_pkg::FUNC_SWITCH;
      default:              cmd.kind = swd_pkg::FUNC_TICK;  // code 3 behaves as a tick
    endcase
    // start, APnDP, RnW, A[1], A[0], parity, stop, park; sent MSB first
    cmd.req_byte = {1'b1, ap_not_dp, read_not_write, reg_addr, req_par, 1'b0, 1'b1};
    cmd.port_dir = {ap_not_dp, read_not_write};
    cmd.wdata    = write_data;
    cmd.wpar     = ^write_data;
    cmd.sdi      = swdio_in;
  end

endmodule

@@ src/swd_line_engine.sv @@
// Back end: bit-serial line engine, one SWCLK period per item.
module swd_line_engine (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [0:0]                cfg_index,
  input  logic [swd_pkg::CFG_W-1:0] cfg_data,
  input  logic                      step,
  input  swd_pkg::swd_cmd_t         cmd,
  output swd_pkg::swd_res_t         res
);

  logic [swd_pkg::CFG_W-1:0] reset_clocks;
  logic [swd_pkg::CFG_W-1:0] low_idle_clocks;

  swd_pkg::swd_phase_t        phase;
  logic [7:0]                 bit_counter;
  logic [swd_pkg::DATA_W-1:0] shift_word;
  logic [7:0]                 request_byte;
  logic [1:0]                 port_dir;
  logic [2:0]                 ack_bits;
  logic [swd_pkg::DATA_W-1:0] received_word;
  logic                       write_parity;

  // state after start handling for this tick
  swd_pkg::swd_phase_t        eff_ph;
  logic [7:0]                 eff_cnt;
  logic [swd_pkg::DATA_W-1:0] eff_sw;
  logic [7:0]                 eff_req;
  logic [1:0]                 eff_pd;
  logic [2:0]                 eff_ack;
  logic                       eff_dp;

  swd_pkg::swd_phase_t        phase_next;
  logic [7:0]                 bit_counter_next;
  logic [swd_pkg::DATA_W-1:0] shift_word_next;
  logic [2:0]                 ack_bits_next;
  logic [swd_pkg::DATA_W-1:0] received_word_next;
  swd_pkg::swd_phase_t        follow_ph;
  logic [7:0]                 ph_len;
  logic                       last_bit;
  logic                       done;
  logic                       lvl;
  logic                       drive;
  logic                       clk_pulse;

  // skips switch-sequence phases whose count is zero
  function automatic swd_pkg::swd_phase_t enter_phase(
    input swd_pkg::swd_phase_t p,
    input logic [7:0]          rc,
    input logic [7:0]          li
  );
    swd_pkg::swd_phase_t q;
    q = p;
    if (q == swd_pkg::PH_RESET1 && rc == '0) q = swd_pkg::PH_PATTERN;
    if (q == swd_pkg::PH_RESET2 && rc == '0) q = swd_pkg::PH_LOWIDLE;
    if (q == swd_pkg::PH_LOWIDLE && li == '0) q = swd_pkg::PH_IDLE;
    return q;
  endfunction

  always_comb begin
    eff_ph  = phase;
    eff_cnt = bit_counter;
    eff_sw  = shift_word;
    eff_req = request_byte;
    eff_pd  = port_dir;
    eff_ack = ack_bits;
    eff_dp  = write_parity;
    if (phase == swd_pkg::PH_IDLE) begin
      if (cmd.kind == swd_pkg::FUNC_XFER) begin
        eff_ph  = swd_pkg::PH_REQ;
        eff_cnt = '0;
        eff_sw  = cmd.wdata;
        eff_req = cmd.req_byte;
        eff_pd  = cmd.port_dir;
        eff_ack = '0;
        eff_dp  = cmd.wpar;
      end else if (cmd.kind == swd_pkg::FUNC_SWITCH) begin
        eff_ph  = enter_phase(swd_pkg::PH_RESET1, reset_clocks, low_idle_clocks);
        eff_cnt = '0;
      end
    end
  end

  // line outputs
  always_comb begin
    lvl       = 1'b1;
    drive     = 1'b1;
    clk_pulse = (eff_ph != swd_pkg::PH_IDLE);
    case (eff_ph)
      swd_pkg::PH_IDLE,
      swd_pkg::PH_RESET1,
      swd_pkg::PH_RESET2:  lvl = 1'b1;
      swd_pkg::PH_PATTERN: lvl = swd_pkg::SWITCH_PATTERN[eff_cnt[3:0]];
      swd_pkg::PH_LOWIDLE: lvl = 1'b0;
      swd_pkg::PH_REQ:     lvl = eff_req[~eff_cnt[2:0]];
      swd_pkg::PH_WDATA:   lvl = eff_sw[eff_cnt[4:0]];
      swd_pkg::PH_WPAR:    lvl = eff_dp;
      default:             drive = 1'b0;  // line released to target
    endcase
  end

  // next state
  always_comb begin
    ack_bits_next      = eff_ack;
    shift_word_next    = eff_sw;
    received_word_next = received_word;
    phase_next         = eff_ph;
    bit_counter_next   = eff_cnt;
    follow_ph          = swd_pkg::PH_IDLE;
    done               = 1'b0;

    case (eff_ph)
      swd_pkg::PH_RESET1,
      swd_pkg::PH_RESET2:  ph_len = reset_clocks;
      swd_pkg::PH_PATTERN: ph_len = 8'd16;
      swd_pkg::PH_LOWIDLE: ph_len = low_idle_clocks;
      swd_pkg::PH_REQ:     ph_len = 8'd8;
      swd_pkg::PH_ACK:     ph_len = 8'd3;
      swd_pkg::PH_RDATA,
      swd_pkg::PH_WDATA:   ph_len = 8'd32;
      swd_pkg::PH_RTAIL:   ph_len = 8'd2;
      default:             ph_len = 8'd1;
    endcase

    if (eff_ph == swd_pkg::PH_ACK && eff_cnt[1:0] != 2'd3) begin
      ack_bits_next[eff_cnt[1:0]] = cmd.sdi;
    end
    if (eff_ph == swd_pkg::PH_RDATA) begin
      shift_word_next[eff_cnt[4:0]] = cmd.sdi;
    end

    case (eff_ph)
      swd_pkg::PH_RESET1:  follow_ph = swd_pkg::PH_PATTERN;
      swd_pkg::PH_PATTERN: follow_ph = swd_pkg::PH_RESET2;
      swd_pkg::PH_RESET2:  follow_ph = swd_pkg::PH_LOWIDLE;
      swd_pkg::PH_REQ:     follow_ph = swd_pkg::PH_TURN1;
      swd_pkg::PH_TURN1:   follow_ph = swd_pkg::PH_ACK;
      swd_pkg::PH_ACK: begin
        if (ack_bits_next == swd_pkg::ACK_OK) begin
          follow_ph = eff_pd[0] ? swd_pkg::PH_RDATA : swd_pkg::PH_TURN2;
        end else if (eff_pd == 2'b11 && ack_bits_next == swd_pkg::ACK_WAIT) begin
          follow_ph = swd_pkg::PH_WAITCLK;  // AP read answered WAIT: a wait-clock phase before idle
        end else begin
          follow_ph = swd_pkg::PH_IDLE;
        end
      end
      swd_pkg::PH_RDATA:   follow_ph = swd_pkg::PH_RTAIL;
      swd_pkg::PH_TURN2:   follow_ph = swd_pkg::PH_WDATA;
      swd_pkg::PH_WDATA:   follow_ph = swd_pkg::PH_WPAR;
      default:             follow_ph = swd_pkg::PH_IDLE;
    endcase

    last_bit = ({1'b0, eff_cnt} + 9'd1) >= {1'b0, ph_len};

    if (eff_ph != swd_pkg::PH_IDLE) begin
      if (last_bit) begin
        if (eff_ph == swd_pkg::PH_RDATA) received_word_next = shift_word_next;
        phase_next       = enter_phase(follow_ph, reset_clocks, low_idle_clocks);
        bit_counter_next = '0;
        done             = (phase_next == swd_pkg::PH_IDLE);
      end else begin
        bit_counter_next = eff_cnt + 8'd1;
      end
    end
  end

  always_comb begin
    res.lvl       = lvl;
    res.drive     = drive;
    res.clk_pulse = clk_pulse;
    res.busy      = (phase_next != swd_pkg::PH_IDLE);
    res.done      = done;
    res.ack       = ack_bits_next;
    res.rword     = received_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_clocks    <= swd_pkg::RESET_CLOCKS_DEFAULT;
      low_idle_clocks <= swd_pkg::LOW_IDLE_DEFAULT;
    end else if (cfg_write) begin
      case (cfg_index)
        swd_pkg::CFG_RESET_CLOCKS: reset_clocks    <= cfg_data;
        swd_pkg::CFG_LOW_IDLE:     low_idle_clocks <= cfg_data;
        default:                   reset_clocks    <= reset_clocks;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= swd_pkg::PH_IDLE;
      bit_counter   <= '0;
      shift_word    <= '0;
      request_byte  <= '0;
      port_dir      <= '0;
      ack_bits      <= '0;
      received_word <= '0;
      write_parity  <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      bit_counter   <= bit_counter_next;
      shift_word    <= shift_word_next;
      request_byte  <= eff_req;
      port_dir      <= eff_pd;
      ack_bits      <= ack_bits_next;
      received_word <= received_word_next;
      write_parity  <= eff_dp;
    end
  end

endmodule
